FILE: hdl/hmu_pkg.sv
`default_nettype none

package hmu_pkg;

    // The ratio S/L carries one integer bit and 32 fraction bits.
    localparam int unsigned RFRAC   = 32;
    localparam int unsigned RBITS   = RFRAC + 1;

    // 1 + r^2 lies in [1, 2] with 32 fraction bits.
    localparam int unsigned XBITS   = 34;

    // The square root takes one root bit per cell over a 66-bit radicand.
    localparam int unsigned RADBITS = 2 * (RBITS);
    localparam int unsigned ROOTW   = RBITS;
    localparam int unsigned SREMW   = 36;

    localparam logic [XBITS-1:0] ONE_Q32 = XBITS'(64'h1_0000_0000);

    typedef logic [RBITS-1:0]   t_ratio;
    typedef logic [ROOTW-1:0]   t_root;
    typedef logic [RADBITS-1:0] t_rad;
    typedef logic [SREMW-1:0]   t_srem;

endpackage

`default_nettype wire

FILE: hdl/hmu_div_cell.sv
`default_nettype none

module hmu_div_cell #(
    parameter int unsigned W = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire [W-1:0]         i_rem,
    input  wire [W-1:0]         i_big,
    input  hmu_pkg::t_ratio     i_q,
    output logic                o_vld,
    output logic [W-1:0]        o_rem,
    output logic [W-1:0]        o_big,
    output hmu_pkg::t_ratio     o_q
);

    logic [W:0]   rem2;
    logic         ge;
    logic [W:0]   diff;

    // One restoring division step: shift in a zero and try to subtract L.
    always_comb begin
        rem2 = {i_rem, 1'b0};
        ge   = (rem2 >= {1'b0, i_big});
        diff = rem2 - {1'b0, i_big};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= ge ? diff[W-1:0] : rem2[W-1:0];
            o_big <= i_big;
            o_q   <= {i_q[hmu_pkg::RBITS-2:0], ge};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hmu_sqrt_cell.sv
`default_nettype none

module hmu_sqrt_cell #(
    parameter int unsigned W = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  hmu_pkg::t_srem      i_rem,
    input  hmu_pkg::t_root      i_root,
    input  hmu_pkg::t_rad       i_rad,
    input  wire [W-1:0]         i_big,
    output logic                o_vld,
    output hmu_pkg::t_srem      o_rem,
    output hmu_pkg::t_root      o_root,
    output hmu_pkg::t_rad       o_rad,
    output logic [W-1:0]        o_big
);

    hmu_pkg::t_srem rem4;
    hmu_pkg::t_srem trial;
    logic           ge;

    // One digit of the restoring square root: bring down two radicand bits
    // and compare against 4*root + 1.
    always_comb begin
        rem4  = {i_rem[hmu_pkg::SREMW-3:0], i_rad[hmu_pkg::RADBITS-1 -: 2]};
        trial = hmu_pkg::SREMW'({i_root, 2'b01});
        ge    = (rem4 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= ge ? (rem4 - trial) : rem4;
            o_root <= {i_root[hmu_pkg::ROOTW-2:0], ge};
            o_rad  <= {i_rad[hmu_pkg::RADBITS-3:0], 2'b00};
            o_big  <= i_big;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hmu_scale.sv
`default_nettype none

module hmu_scale #(
    parameter int unsigned W = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  wire [W-1:0]         i_big,
    input  hmu_pkg::t_root      i_root,
    output logic                o_vld,
    output logic [W-1:0]        o_mag
);

    localparam int unsigned HALF = (W + 1) / 2;
    localparam int unsigned HI   = W - HALF;
    localparam int unsigned PW   = W + hmu_pkg::ROOTW;

    logic                              r_vld0;
    logic [HALF+hmu_pkg::ROOTW-1:0]    r_plo;
    logic [HI+hmu_pkg::ROOTW-1:0]      r_phi;
    logic [PW-1:0]                     sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            o_vld  <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_vld;
            o_vld  <= r_vld0;
        end
    end

    // L times the root factor as two half-width partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= i_big[HALF-1:0] * i_root;
            r_phi <= i_big[W-1:HALF] * i_root;
        end
    end

    // Recombine and drop the 32 fraction bits of the factor.
    always_comb begin
        sum = (PW'(r_phi) << HALF) + PW'(r_plo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag <= sum[W+hmu_pkg::RFRAC-1:hmu_pkg::RFRAC];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hypotenuse_magnitude_unit.sv
// Throughput: one beat per cycle; the chain of 32 divider cells and 33
// square-root cells advances as one pipeline whenever the output register
// is empty or being taken.
// Reset clears all valid bits; the data path holds no state across items.
`default_nettype none

module hypotenuse_magnitude_unit #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire [DATA_WIDTH-1:0]    i_a_value,
    input  wire [DATA_WIDTH-1:0]    i_b_value,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [DATA_WIDTH-1:0]   o_magnitude
);

    localparam int unsigned W     = DATA_WIDTH;
    localparam int unsigned NDIV  = hmu_pkg::RFRAC;
    localparam int unsigned NSQRT = hmu_pkg::ROOTW;

    logic en;

    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic         r_vld_a;
    logic [W-1:0] r_big;
    logic [W-1:0] r_small;
    logic         ge0;

    logic                   dv_vld [NDIV+1];
    logic [W-1:0]           dv_rem [NDIV+1];
    logic [W-1:0]           dv_big [NDIV+1];
    hmu_pkg::t_ratio        dv_q   [NDIV+1];

    logic                   r_vld_sq;
    logic [hmu_pkg::XBITS-1:0] r_x;
    logic [W-1:0]           r_big_sq;
    logic [hmu_pkg::XBITS-1:0] r2;
    logic [63:0]            rprod;

    logic                   sq_vld  [NSQRT+1];
    hmu_pkg::t_srem         sq_rem  [NSQRT+1];
    hmu_pkg::t_root         sq_root [NSQRT+1];
    hmu_pkg::t_rad          sq_rad  [NSQRT+1];
    logic [W-1:0]           sq_big  [NSQRT+1];

    // The whole chain moves when the output register can take a new beat.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Leg magnitudes; the most negative value maps to 2^(W-1) exactly.
    always_comb begin
        mag_a = i_a_value[W-1] ? (~i_a_value + W'(1)) : i_a_value;
        mag_b = i_b_value[W-1] ? (~i_b_value + W'(1)) : i_b_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (en) begin
            r_vld_a <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_big   <= (mag_a > mag_b) ? mag_a : mag_b;
            r_small <= (mag_a > mag_b) ? mag_b : mag_a;
        end
    end

    // Integer bit of the ratio, which is set only when the legs are equal.
    always_comb begin
        ge0 = (r_small >= r_big);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_vld[0] <= 1'b0;
        end else if (en) begin
            dv_vld[0] <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dv_rem[0] <= ge0 ? (r_small - r_big) : r_small;
            dv_big[0] <= r_big;
            dv_q[0]   <= hmu_pkg::RBITS'(ge0);
        end
    end

    // Fraction bits of S/L, one per cell.
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        hmu_div_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[k]),
            .i_rem   (dv_rem[k]),
            .i_big   (dv_big[k]),
            .i_q     (dv_q[k]),
            .o_vld   (dv_vld[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_big   (dv_big[k+1]),
            .o_q     (dv_q[k+1])
        );
    end

    // r^2 truncated to 32 fraction bits; r equal to one squares to one.
    always_comb begin
        rprod = dv_q[NDIV][hmu_pkg::RFRAC-1:0] * dv_q[NDIV][hmu_pkg::RFRAC-1:0];
        r2    = dv_q[NDIV][hmu_pkg::RFRAC] ? hmu_pkg::ONE_Q32
                                           : hmu_pkg::XBITS'(rprod[63:32]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sq <= 1'b0;
        end else if (en) begin
            r_vld_sq <= dv_vld[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x      <= hmu_pkg::ONE_Q32 + r2;
            r_big_sq <= dv_big[NDIV];
        end
    end

    // Seed of the square-root chain: radicand is (1 + r^2) * 2^32.
    assign sq_vld[0]  = r_vld_sq;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = {hmu_pkg::RADBITS'(r_x)} << hmu_pkg::RFRAC;
    assign sq_big[0]  = r_big_sq;

    for (genvar k = 0; k < NSQRT; k++) begin : g_sqrt
        hmu_sqrt_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_rad   (sq_rad[k]),
            .i_big   (sq_big[k]),
            .o_vld   (sq_vld[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_big   (sq_big[k+1])
        );
    end

    // Scale the root factor by L; the last register is the output register.
    hmu_scale #(.W(W)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld[NSQRT]),
        .i_big   (sq_big[NSQRT]),
        .i_root  (sq_root[NSQRT]),
        .o_vld   (o_out_valid),
        .o_mag   (o_magnitude)
    );

endmodule

`default_nettype wire

FILE: hdl/hmu_checker.sv
`default_nettype none

module hmu_checker #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_in_ready,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire [DATA_WIDTH-1:0] o_magnitude
);

    // A result beat that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_magnitude))
        else $error("result beat changed while stalled");

    // An empty output register never blocks the input side.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // The input side is held off only by a stalled result beat.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

    // Reset leaves no result beat behind.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

endmodule

bind hypotenuse_magnitude_unit hmu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_hmu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_magnitude (o_magnitude)
);

`default_nettype wire

FILE: verif/hypotenuse_magnitude_unit_test.sv
`timescale 1ns / 100ps

module hypotenuse_magnitude_unit_test;

    localparam int unsigned DW = 32;
    localparam int LATENCY = 70;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [DW-1:0] a_leg;
        logic [DW-1:0] b_leg;
    } t_leg_pair;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    logic [DW-1:0]  i_a_value = '0;
    logic [DW-1:0]  i_b_value = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    logic [DW-1:0]  o_magnitude;

    t_leg_pair      pending_pairs[$];
    logic [DW-1:0]  expected_magnitudes[$];
    int             error_count = 0;
    int             checked_count = 0;
    longint         cycle_count = 0;
    bit             calm_stretch = 1'b0;
    bit             hold_sender = 1'b0;
    bit             stimulus_done = 1'b0;

    hypotenuse_magnitude_unit #(.DATA_WIDTH(DW)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_a_value   (i_a_value),
        .i_b_value   (i_b_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_magnitude (o_magnitude)
    );

    always #2 i_clk = ~i_clk;

    // Magnitude of a two's complement leg, one bit wider to hold the most negative value.
    function automatic logic [DW:0] leg_magnitude(input logic [DW-1:0] v);
        logic [DW:0] m;
        m = v[DW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        return m;
    endfunction

    // Fixed-point hypotenuse: ratio, square, root of one plus square, scale by the long leg.
    function automatic logic [DW-1:0] hypot_of(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0]   ma, mb, long_leg, short_leg;
        logic [63:0]   ratio, ratio_sq, radicand_hi, root, cand;
        logic [127:0]  radicand, cand_sq, scaled;
        ma = leg_magnitude(a);
        mb = leg_magnitude(b);
        long_leg = (ma > mb) ? ma : mb;
        short_leg = (ma > mb) ? mb : ma;
        if (long_leg == 0) return '0;
        ratio = ({31'b0, short_leg} << 32) / {31'b0, long_leg};
        if (ratio >= 64'h1_0000_0000)
            ratio_sq = 64'h1_0000_0000;
        else
            ratio_sq = (ratio * ratio) >> 32;
        radicand_hi = 64'h1_0000_0000 + ratio_sq;
        radicand = {64'b0, radicand_hi} << 32;
        root = '0;
        for (int bit_idx = 33; bit_idx >= 0; bit_idx--) begin
            cand = root | (64'd1 << bit_idx);
            cand_sq = {64'b0, cand} * {64'b0, cand};
            if (cand_sq <= radicand) root = cand;
        end
        scaled = {95'b0, long_leg} * {64'b0, root};
        return scaled[32 +: DW];
    endfunction

    function automatic logic [DW-1:0] random_leg();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = $urandom_range(0, 255);
            3: v = -$urandom_range(0, 255);
            4: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Driver: presents queued beats and keeps valid up until the beat is taken.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (pending_pairs.size() != 0 && !hold_sender
                        && (calm_stretch || $urandom_range(0, 99) >= 30)) begin
                    t_leg_pair p;
                    p = pending_pairs.pop_front();
                    i_in_valid <= 1'b1;
                    i_a_value <= p.a_leg;
                    i_b_value <= p.b_leg;
                    expected_magnitudes.push_back(hypot_of(p.a_leg, p.b_leg));
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= calm_stretch || ($urandom_range(0, 99) >= 30);
        end
    end

    // Monitor: compares each result beat with the oldest expected magnitude.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_magnitudes.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, o_magnitude);
                error_count <= error_count + 1;
            end else begin
                logic [DW-1:0] want;
                want = expected_magnitudes.pop_front();
                if (o_magnitude !== want) begin
                    $display("%0t: magnitude mismatch, expected %h, actual %h",
                             $time, want, o_magnitude);
                    error_count <= error_count + 1;
                end
                checked_count <= checked_count + 1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [DW-1:0] extremes[6];
        extremes = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        // Directed: zero, extremes in every combination, equal magnitudes, one bit legs.
        foreach (extremes[i])
            foreach (extremes[j])
                if (i <= j) pending_pairs.push_back('{extremes[i], extremes[j]});
        pending_pairs.push_back('{32'h0003_0000, 32'hFFFC_0000});
        pending_pairs.push_back('{32'h1234_5678, 32'hEDCB_A988});
        pending_pairs.push_back('{32'hAAAA_AAAA, 32'h5555_5555});
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_pairs.size() == 0);

        // Pause the sender until the pipeline has fully drained.
        hold_sender = 1'b1;
        wait (expected_magnitudes.size() == 0 && !i_in_valid);
        hold_sender = 1'b0;

        for (int n = 0; n < 1300; n++) begin
            t_leg_pair p;
            p.a_leg = random_leg();
            p.b_leg = ($urandom_range(0, 9) == 0) ? -p.a_leg : random_leg();
            pending_pairs.push_back(p);
            if (n == 500) begin
                wait (pending_pairs.size() == 0);
                calm_stretch = 1'b1;
            end
            if (n == 800) begin
                wait (pending_pairs.size() == 0);
                calm_stretch = 1'b0;
            end
        end
        wait (pending_pairs.size() == 0 && !i_in_valid);
        wait (expected_magnitudes.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d magnitudes from zero, extreme, equal and random legs,", checked_count);
        $display("with random gaps and back-pressure on both sides and one full drain.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
